>>> rtl/core/teq_pkg.sv
`timescale 1ns / 1ps
package teq_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TICK   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_FIRED   = 3'd0,
    KIND_ADDED   = 3'd1,
    KIND_DROPPED = 3'd2,
    KIND_REMOVED = 3'd3,
    KIND_NONE    = 3'd4
  } kind_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [31:0]        time_value;
    logic [7:0]         delay_type;
    logic [15:0]        effect_type;
    logic [15:0]        target_handle;
    logic [7:0]         target_type;
    logic [7:0]         map_index;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [31:0] value1;
    logic signed [31:0] value2;
    logic signed [31:0] value3;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic               last;
    logic [7:0]         fired_delay_type;
    logic [15:0]        fired_effect_type;
    logic [15:0]        fired_target_handle;
    logic [7:0]         fired_target_type;
    logic [7:0]         fired_map_index;
    logic signed [15:0] fired_pos_x;
    logic signed [15:0] fired_pos_y;
    logic signed [31:0] fired_value1;
    logic signed [31:0] fired_value2;
    logic signed [31:0] fired_value3;
  } out_item_t;

  // Stored event: trigger time plus carried fields
  typedef struct packed {
    logic [31:0] time_value;
    logic [7:0]  delay_type;
    logic [15:0] effect_type;
    logic [15:0] target_handle;
    logic [7:0]  target_type;
    logic [7:0]  map_index;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [31:0] value1;
    logic [31:0] value2;
    logic [31:0] value3;
  } event_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic        insert;   // insert new event at its sorted place
    logic        shift;    // every cell takes the event of its right neighbor
    logic        remove;   // drop matching cells, compact one step a cycle
    logic        clear;    // invalidate all
    logic [31:0] time_value;
    logic [15:0] effect_type;
    logic [15:0] target_handle;
    logic [7:0]  target_type;
  } cell_cmd_t;

endpackage

>>> rtl/core/teq_cell.sv
`timescale 1ns / 1ps
module teq_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  teq_pkg::cell_cmd_t cmd_i,
  input  teq_pkg::event_t   new_ev_i,
  // left neighbor (lower index)
  input  logic              left_valid_i,
  input  logic              left_place_i,
  input  teq_pkg::event_t   left_ev_i,
  // right neighbor (higher index)
  input  logic              right_valid_i,
  input  teq_pkg::event_t   right_ev_i,
  output logic              valid_o,
  output logic              place_o,
  output logic              hole_o,
  output teq_pkg::event_t   ev_o
);
  import teq_pkg::*;

  logic   valid_q, valid_d;
  event_t ev_q, ev_d;
  logic   later, hit;

  // place_o: new event goes at or left of this cell
  assign later   = !valid_q || (ev_q.time_value > cmd_i.time_value);
  assign place_o = later;
  assign hit = valid_q && ev_q.target_handle == cmd_i.target_handle &&
               ev_q.target_type == cmd_i.target_type &&
               (cmd_i.effect_type == '0 || ev_q.effect_type == cmd_i.effect_type);
  // hole_o: this cell must be refilled from the right
  assign hole_o = hit;

  always_comb begin
    valid_d = valid_q;
    ev_d    = ev_q;
    if (cmd_i.clear) begin
      valid_d = 1'b0;
    end else if (cmd_i.insert) begin
      if (later && !left_place_i) begin
        valid_d = 1'b1;
        ev_d    = new_ev_i;
      end else if (later) begin
        valid_d = left_valid_i;
        ev_d    = left_ev_i;
      end
    end else if (cmd_i.shift) begin
      valid_d = right_valid_i;
      ev_d    = right_ev_i;
    end else if (cmd_i.remove) begin
      // pull from the right when this cell or any left of it is a hit
      if (left_place_i || hit) begin
        valid_d = right_valid_i;
        ev_d    = right_ev_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q <= ev_d;
  end

  assign valid_o = valid_q;
  assign ev_o    = ev_q;

endmodule

>>> rtl/core/timed_event_queue_core.sv
`timescale 1ns / 1ps
// Timed event queue built as a row of cells, one event per cell, sorted by
// trigger time with ties in arrival order (cell 0 is the head).
// Input channel in_valid_i/in_stall_o/in_item_i; output channel
// out_valid_o/out_stall_i/out_item_o. Every item gives at least one result;
// the last result of an item carries last = 1.
// Add: the insert runs in the cycle after the transfer (each cell compares
// and shifts right) and the result is registered at the end of that cycle;
// the input stalls meanwhile.
// Clear: the result is registered at the transfer edge itself.
// Remove: the row compacts one matching event per cycle; once no match is
// left and the output register is free, the result is registered and the
// queue returns to idle for the next item.
// Tick: each fired event leaves the head as the row shifts left by one cell,
// one result per cycle while the receiver takes them.
// Reset empties the queue and the output register at once.
// A stalled result is held in the output register; the row waits with it.
module timed_event_queue_core #(
  parameter int DEPTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  teq_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output teq_pkg::out_item_t out_item_o
);
  import teq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_REMOVE = 2'd1,
    ST_TICK   = 2'd2
  } state_e;

  state_e    state_q, state_d;
  in_item_t  item_q, item_d;
  cell_cmd_t cmd;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;
  logic      add_pend_q;

  logic   [DEPTH-1:0] c_valid, c_place, c_hole;
  event_t             c_ev [DEPTH];
  logic   [DEPTH:0]   pre;
  event_t             new_ev;
  logic               accept, out_free, full, any_hit, head_due;

  assign new_ev = '{time_value: item_q.time_value, delay_type: item_q.delay_type,
                    effect_type: item_q.effect_type,
                    target_handle: item_q.target_handle,
                    target_type: item_q.target_type, map_index: item_q.map_index,
                    pos_x: item_q.pos_x, pos_y: item_q.pos_y, value1: item_q.value1,
                    value2: item_q.value2, value3: item_q.value3};

  // first-hit prefix: pre[i] = a hit exists in cells below i
  assign pre[0] = 1'b0;
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic   lv, lp;
    event_t lev;
    logic   rv;
    event_t rev;
    if (g == 0) begin : g_l0
      assign lv = 1'b0; assign lev = new_ev;
    end else begin : g_ln
      assign lv = c_valid[g-1]; assign lev = c_ev[g-1];
    end
    if (g == DEPTH - 1) begin : g_rl
      assign rv = 1'b0; assign rev = c_ev[g];
    end else begin : g_rn
      assign rv = c_valid[g+1]; assign rev = c_ev[g+1];
    end
    // insert: left neighbor already past the new time; remove: hit below
    assign lp = cmd.insert ? ((g == 0) ? 1'b0 : c_place[g-1]) : pre[g];
    assign pre[g+1] = pre[g] || c_hole[g];
    teq_cell u_cell (
      .clk_i, .rst_ni, .cmd_i(cmd), .new_ev_i(new_ev),
      .left_valid_i(lv), .left_place_i(lp), .left_ev_i(lev),
      .right_valid_i(rv), .right_ev_i(rev),
      .valid_o(c_valid[g]), .place_o(c_place[g]), .hole_o(c_hole[g]),
      .ev_o(c_ev[g])
    );
  end

  assign full     = c_valid[DEPTH-1];
  assign any_hit  = pre[DEPTH];
  assign head_due = c_valid[0] && (c_ev[0].time_value <= item_q.time_value);
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || add_pend_q || !out_free;
  assign accept   = in_valid_i && !in_stall_o;

  // sequencer: decode, compact, drain fired events
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    cmd         = '0;
    cmd.time_value    = item_q.time_value;
    cmd.effect_type   = item_q.effect_type;
    cmd.target_handle = item_q.target_handle;
    cmd.target_type   = item_q.target_type;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          item_d = in_item_i;
          case (op_e'(in_item_i.op))
            OP_REMOVE: state_d = ST_REMOVE;
            OP_TICK:   state_d = ST_TICK;
            OP_CLEAR: begin
              cmd.clear   = 1'b1;
              out_valid_d = 1'b1;
              out_d       = '0;
              out_d.kind  = KIND_REMOVED;
              out_d.last  = 1'b1;
            end
            default: state_d = ST_REMOVE; // add: overridden to idle just below
          endcase
          if (op_e'(in_item_i.op) == OP_ADD) state_d = ST_IDLE;
        end
        // add completes in the next cycle via the pending flag
      end
      ST_REMOVE: begin
        if (any_hit) begin
          cmd.remove = 1'b1;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.kind  = KIND_REMOVED;
          out_d.last  = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_TICK: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          if (head_due) begin
            cmd.shift  = 1'b1;
            out_d.kind = KIND_FIRED;
            out_d.fired_delay_type    = c_ev[0].delay_type;
            out_d.fired_effect_type   = c_ev[0].effect_type;
            out_d.fired_target_handle = c_ev[0].target_handle;
            out_d.fired_target_type   = c_ev[0].target_type;
            out_d.fired_map_index     = c_ev[0].map_index;
            out_d.fired_pos_x         = c_ev[0].pos_x;
            out_d.fired_pos_y         = c_ev[0].pos_y;
            out_d.fired_value1        = c_ev[0].value1;
            out_d.fired_value2        = c_ev[0].value2;
            out_d.fired_value3        = c_ev[0].value3;
            out_d.last = !(c_valid[1 % DEPTH] && DEPTH > 1 &&
                           c_ev[1 % DEPTH].time_value <= item_q.time_value);
            if (out_d.last) state_d = ST_IDLE;
          end else begin
            out_d.kind = KIND_NONE;
            out_d.last = 1'b1;
            state_d    = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // add: insert in the cycle after acceptance
    if (add_pend_q) begin
      cmd.insert  = !full;
      out_valid_d = 1'b1;
      out_d       = '0;
      out_d.kind  = full ? KIND_DROPPED : KIND_ADDED;
      out_d.last  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      add_pend_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      add_pend_q  <= accept && (op_e'(in_item_i.op) == OP_ADD);
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // hold the input while an add is pending: no new transfer until it lands
  ap_add_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    add_pend_q |-> in_stall_o) else $error("transfer during pending add");
  ap_tick_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.shift |-> c_valid[0]) else $error("shift from empty head");
  ap_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd.insert, cmd.shift, cmd.remove, cmd.clear}) <= 1)
    else $error("conflicting cell commands");
  ap_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.insert |-> !full) else $error("insert into full row");

endmodule

>>> tb/sv/timed_event_queue_core_tb.sv
`timescale 1ns / 1ps
module timed_event_queue_core_tb;
  import teq_pkg::*;

  localparam int DEPTH = 32;
  localparam int CYCLE_LIMIT = 400000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  timed_event_queue_core #(.DEPTH(DEPTH)) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always #6 clk_i = ~clk_i;

  // Shadow queue of pending events, head at index 0
  in_item_t  pending_events[$];
  out_item_t expected_results[$];
  int        mismatch_count = 0;
  int        result_count = 0;
  int        fired_count = 0;
  int        item_count = 0;
  int        cycle_count = 0;
  int        send_gap_pct = 0;
  int        recv_stall_pct = 0;

  // Compute the results of one item and advance the shadow queue
  task automatic predict_queue_op(input in_item_t it);
    out_item_t res;
    in_item_t  kept[$];
    int        pos;
    int        n;
    res = '0;
    res.last = 1'b1;
    case (op_e'(it.op))
      OP_ADD: begin
        if (pending_events.size() >= DEPTH) begin
          res.kind = KIND_DROPPED;
        end else begin
          pos = 0;
          while (pos < pending_events.size() &&
                 pending_events[pos].time_value <= it.time_value) pos++;
          pending_events.insert(pos, it);
          res.kind = KIND_ADDED;
        end
        expected_results.push_back(res);
      end
      OP_REMOVE: begin
        foreach (pending_events[i]) begin
          if (!(pending_events[i].target_handle == it.target_handle &&
                pending_events[i].target_type == it.target_type &&
                (it.effect_type == 16'd0 ||
                 pending_events[i].effect_type == it.effect_type)))
            kept.push_back(pending_events[i]);
        end
        pending_events = kept;
        res.kind = KIND_REMOVED;
        expected_results.push_back(res);
      end
      OP_TICK: begin
        n = 0;
        while (n < pending_events.size() &&
               pending_events[n].time_value <= it.time_value) n++;
        if (n == 0) begin
          res.kind = KIND_NONE;
          expected_results.push_back(res);
        end
        for (int i = 0; i < n; i++) begin
          res = '0;
          res.kind = KIND_FIRED;
          res.last = (i == n - 1);
          res.fired_delay_type    = pending_events[0].delay_type;
          res.fired_effect_type   = pending_events[0].effect_type;
          res.fired_target_handle = pending_events[0].target_handle;
          res.fired_target_type   = pending_events[0].target_type;
          res.fired_map_index     = pending_events[0].map_index;
          res.fired_pos_x         = pending_events[0].pos_x;
          res.fired_pos_y         = pending_events[0].pos_y;
          res.fired_value1        = pending_events[0].value1;
          res.fired_value2        = pending_events[0].value2;
          res.fired_value3        = pending_events[0].value3;
          expected_results.push_back(res);
          void'(pending_events.pop_front());
        end
      end
      default: begin
        pending_events.delete();
        res.kind = KIND_REMOVED;
        expected_results.push_back(res);
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    $display("ERROR result %0d: %s got %0h want %0h", result_count, what, got, want);
  endtask

  // Send one item, holding it until the transfer; valid stays high after it
  task automatic send_item(input in_item_t it);
    while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_queue_op(it);
    item_count++;
  endtask

  // Random stall on the result side
  always @(posedge clk_i) begin
    out_stall_i <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Check each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_item_o.kind), 64'(0));
      end else begin
        want = expected_results.pop_front();
        if (want.kind == KIND_FIRED) fired_count++;
        if (out_item_o.kind != want.kind)
          report_mismatch("kind", 64'(out_item_o.kind), 64'(want.kind));
        if (out_item_o.last != want.last)
          report_mismatch("last", 64'(out_item_o.last), 64'(want.last));
        if (out_item_o.fired_delay_type != want.fired_delay_type)
          report_mismatch("delay_type", 64'(out_item_o.fired_delay_type),
                          64'(want.fired_delay_type));
        if (out_item_o.fired_effect_type != want.fired_effect_type)
          report_mismatch("effect_type", 64'(out_item_o.fired_effect_type),
                          64'(want.fired_effect_type));
        if (out_item_o.fired_target_handle != want.fired_target_handle)
          report_mismatch("target_handle", 64'(out_item_o.fired_target_handle),
                          64'(want.fired_target_handle));
        if (out_item_o.fired_target_type != want.fired_target_type)
          report_mismatch("target_type", 64'(out_item_o.fired_target_type),
                          64'(want.fired_target_type));
        if (out_item_o.fired_map_index != want.fired_map_index)
          report_mismatch("map_index", 64'(out_item_o.fired_map_index),
                          64'(want.fired_map_index));
        if (out_item_o.fired_pos_x != want.fired_pos_x)
          report_mismatch("pos_x", 64'(out_item_o.fired_pos_x), 64'(want.fired_pos_x));
        if (out_item_o.fired_pos_y != want.fired_pos_y)
          report_mismatch("pos_y", 64'(out_item_o.fired_pos_y), 64'(want.fired_pos_y));
        if (out_item_o.fired_value1 != want.fired_value1)
          report_mismatch("value1", 64'(out_item_o.fired_value1),
                          64'(want.fired_value1));
        if (out_item_o.fired_value2 != want.fired_value2)
          report_mismatch("value2", 64'(out_item_o.fired_value2),
                          64'(want.fired_value2));
        if (out_item_o.fired_value3 != want.fired_value3)
          report_mismatch("value3", 64'(out_item_o.fired_value3),
                          64'(want.fired_value3));
      end
      result_count++;
    end
  end

  // Abort on a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic in_item_t make_event(input op_e op, input logic [31:0] t);
    in_item_t it;
    it = '0;
    it.op            = op;
    it.time_value    = t;
    it.delay_type    = 8'($urandom);
    it.effect_type   = 16'($urandom_range(3));
    it.target_handle = 16'($urandom_range(3));
    it.target_type   = 8'($urandom_range(1));
    it.map_index     = 8'($urandom);
    it.pos_x         = 16'($urandom);
    it.pos_y         = 16'($urandom);
    it.value1        = $urandom;
    it.value2        = $urandom;
    it.value3        = $urandom;
    return it;
  endfunction

  // Drop valid and wait until every expected result has come
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Field extremes, tie order, full queue, remove variants, clear
  task automatic test_directed();
    in_item_t it;
    it = '1;
    it.op = OP_ADD;
    send_item(it);
    it = '0;
    it.op = OP_ADD;
    send_item(it);
    send_item(make_event(OP_ADD, 32'd5));
    send_item(make_event(OP_ADD, 32'd5));
    send_item(make_event(OP_TICK, 32'd0));
    send_item(make_event(OP_TICK, 32'd4));
    send_item(make_event(OP_TICK, 32'd5));
    it = '0;
    it.op = OP_REMOVE;
    it.target_handle = 16'hffff;
    it.target_type = 8'hff;
    send_item(it);
    send_item(make_event(OP_TICK, 32'hffff_ffff));
    for (int i = 0; i < DEPTH + 2; i++) send_item(make_event(OP_ADD, $urandom_range(40)));
    it = make_event(OP_REMOVE, 0);
    send_item(it);
    it.effect_type = 16'd0;
    send_item(it);
    it.target_handle = 16'h1234;
    send_item(it);
    send_item(make_event(OP_CLEAR, $urandom));
    send_item(make_event(OP_TICK, 32'hffff_ffff));
    wait_drained();
  endtask

  // Mostly adds with some ticks at advancing time, plus noise
  task automatic test_random(input int count, input int gap, input int stall);
    logic [31:0] now;
    int          sel;
    send_gap_pct = gap;
    recv_stall_pct = stall;
    now = $urandom_range(1000);
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 55) send_item(make_event(OP_ADD, now + $urandom_range(60)));
      else if (sel < 80) begin
        now = now + $urandom_range(40);
        send_item(make_event(OP_TICK, now));
      end else if (sel < 93) send_item(make_event(OP_REMOVE, 0));
      else if (sel < 97) send_item(make_event(OP_CLEAR, $urandom));
      else send_item(make_event(OP_ADD, $urandom));
      if (i == count / 2) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_random(27, 8, 45);
    test_random(27, 45, 8);
    test_random(27, 0, 0);
    send_item(make_event(OP_TICK, 32'hffff_ffff));
    wait_drained();
    $display("Ran %0d items, %0d results, %0d fired events", item_count, result_count,
             fired_count);
    $display("Covered add, full drop, remove, clear and tick under both stall patterns");
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/teq_pkg.sv
rtl/core/teq_cell.sv
rtl/core/timed_event_queue_core.sv
tb/sv/timed_event_queue_core_tb.sv
